// File: rtl/core/cbse_pkg.sv
// Package for the character buffer sort engine: sizes, operation codes
// and the request/result payload structs. No dependencies.
package cbse_pkg;
  localparam int unsigned MaxLen = 64;
  localparam int unsigned IdxW = $clog2(MaxLen);
  localparam int unsigned LenW = $clog2(MaxLen + 1);

  typedef enum logic [2:0] {
    FuncClear   = 3'd0,
    FuncAppend  = 3'd1,
    FuncSort    = 3'd2,
    FuncReverse = 3'd3,
    FuncCount   = 3'd4,
    FuncRemove  = 3'd5,
    FuncRead    = 3'd6,
    FuncNone    = 3'd7
  } func_e;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_in;
  } req_t;

  typedef struct packed {
    logic [7:0] data_char;
    logic       has_char;
    logic [6:0] match_count;
    logic       last;
    logic       status;
  } rsp_t;
endpackage

// File: rtl/core/character_buffer_sort_engine_top.sv
// Character buffer sort engine: 64-byte word store, one registered read port and
// one compare unit stepped by a sequencer. Depends on cbse_pkg.
// Clear and append answer on acceptance; count and remove scan the word once;
// reverse swaps pairs from both ends; sort does one store read per compare;
// read out gives one character per result and waits for each to be taken.
// One request at a time; reset (async, active low) empties the word only.
module character_buffer_sort_engine_top
  import cbse_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);
  typedef enum logic [3:0] {
    StIdle, StRd, StUse, StSwA, StSwB, StOut, StWait
  } state_e;

  state_e       state_q;
  func_e        func_q;
  logic [7:0]   ch_q;
  logic [LenW-1:0] len_q, i_q, j_q, k_q, n_q, lo_q;
  logic [7:0]   min_q, a_q, mem_rd_q;
  logic [IdxW-1:0] rd_addr;
  logic [7:0]   mem_q [MaxLen];
  logic         we;
  logic [IdxW-1:0] wa;
  logic [7:0]   wd;
  logic         phase_q;
  rsp_t         acc_rsp;

  assign in_ready_o = (state_q == StIdle) && !out_valid_o;

  // Single store with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    mem_rd_q <= mem_q[rd_addr];
  end

  // Read address: sort scans j, the first swap state uses lo; reverse uses i/k; others j.
  always_comb begin
    rd_addr = j_q[IdxW-1:0];
    if (state_q == StSwA) rd_addr = lo_q[IdxW-1:0];
    if (func_q == FuncReverse && state_q == StRd)
      rd_addr = phase_q ? k_q[IdxW-1:0] : i_q[IdxW-1:0];
  end

  // Result taken on acceptance: length after the request, or status on a full append.
  always_comb begin
    acc_rsp = '{data_char: 8'd0, has_char: 1'b0,
                match_count: 7'(len_q), last: 1'b1, status: 1'b0};
    case (func_e'(in_req_i.func))
      FuncClear: acc_rsp.match_count = '0;
      FuncAppend: begin
        if (len_q < LenW'(MaxLen)) acc_rsp.match_count = 7'(len_q + 1'b1);
        else acc_rsp.status = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b0; wa = '0; wd = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o && in_req_i.func == FuncAppend &&
            len_q < LenW'(MaxLen)) begin
          we = 1'b1; wa = len_q[IdxW-1:0]; wd = in_req_i.char_in;
        end
      end
      StUse: begin
        if (func_q == FuncRemove && mem_rd_q != ch_q) begin
          we = 1'b1; wa = k_q[IdxW-1:0]; wd = mem_rd_q;
        end
        if (func_q == FuncReverse && phase_q) begin
          we = 1'b1; wa = i_q[IdxW-1:0]; wd = mem_rd_q;
        end
      end
      StSwA: begin we = 1'b1; wa = lo_q[IdxW-1:0]; wd = a_q; end
      StSwB: begin
        if (func_q == FuncSort) begin
          we = 1'b1; wa = i_q[IdxW-1:0]; wd = min_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; len_q <= '0; out_valid_o <= 1'b0;
      func_q <= FuncNone; phase_q <= 1'b0; ch_q <= '0;
      i_q <= '0; j_q <= '0; k_q <= '0; n_q <= '0; lo_q <= '0;
      min_q <= '0; a_q <= '0; out_rsp_o <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            func_q <= func_e'(in_req_i.func);
            ch_q <= in_req_i.char_in;
            i_q <= '0; j_q <= '0; k_q <= '0; n_q <= '0; phase_q <= 1'b0;
            out_rsp_o <= acc_rsp;
            case (func_e'(in_req_i.func))
              FuncClear: begin
                len_q <= '0; out_valid_o <= 1'b1;
              end
              FuncAppend: begin
                if (len_q < LenW'(MaxLen)) len_q <= len_q + 1'b1;
                out_valid_o <= 1'b1;
              end
              FuncSort: begin
                // Start pass i=0: first compare reads j=i.
                if (len_q == '0) out_valid_o <= 1'b1; else state_q <= StRd;
              end
              FuncReverse: begin
                k_q <= len_q - 1'b1;
                if (len_q < LenW'(2)) out_valid_o <= 1'b1; else state_q <= StRd;
              end
              FuncCount, FuncRemove, FuncRead: begin
                if (len_q == '0) out_valid_o <= 1'b1;
                else state_q <= StRd;
              end
              default: ;
            endcase
          end
        end
        StRd: state_q <= StUse;  // registered read lands next cycle
        StUse: begin
          state_q <= StRd;
          case (func_q)
            FuncSort: begin
              if (j_q == i_q || mem_rd_q < min_q) begin
                min_q <= mem_rd_q; lo_q <= j_q;
              end
              if (j_q == i_q) a_q <= mem_rd_q;
              if (j_q + 1'b1 == len_q) state_q <= StSwA;
              else j_q <= j_q + 1'b1;
            end
            FuncReverse: begin
              // Phase 0 holds store[i]; phase 1 writes store[k] to i, then k<-held.
              if (!phase_q) begin a_q <= mem_rd_q; phase_q <= 1'b1; end
              else begin
                lo_q <= k_q; phase_q <= 1'b0;
                state_q <= StSwA;
              end
            end
            FuncCount, FuncRemove: begin
              if (mem_rd_q == ch_q) n_q <= n_q + 1'b1;
              else k_q <= k_q + 1'b1;
              if (j_q + 1'b1 == len_q) begin
                state_q <= StOut;
              end else j_q <= j_q + 1'b1;
            end
            FuncRead: begin
              out_rsp_o <= '{data_char: mem_rd_q, has_char: 1'b1,
                             match_count: 7'(len_q),
                             last: (j_q + 1'b1 == len_q), status: 1'b0};
              out_valid_o <= 1'b1;
              state_q <= StWait;
            end
            default: state_q <= StIdle;
          endcase
        end
        StSwA: begin
          // Sort: store[lo] <- old store[i]; reverse: store[k] <- old store[i].
          state_q <= StSwB;
        end
        StSwB: begin
          if (func_q == FuncReverse) begin
            // Advance the pair; stop once the indices meet or cross.
            if (i_q + 1'b1 >= k_q - 1'b1 || i_q + 1'b1 >= k_q) begin
              out_valid_o <= 1'b1; state_q <= StIdle;
            end else state_q <= StRd;
            i_q <= i_q + 1'b1; k_q <= k_q - 1'b1;
          end else begin
            if (i_q + 1'b1 >= len_q) begin
              out_valid_o <= 1'b1; state_q <= StIdle;
            end else begin
              i_q <= i_q + 1'b1; j_q <= i_q + 1'b1; state_q <= StRd;
            end
          end
        end
        StOut: begin
          out_rsp_o.match_count <= 7'(n_q);
          if (func_q == FuncRemove) len_q <= k_q;
          out_valid_o <= 1'b1; state_q <= StIdle;
        end
        StWait: begin
          if (out_valid_o && out_ready_i) begin
            if (j_q + 1'b1 == len_q) state_q <= StIdle;
            else begin j_q <= j_q + 1'b1; state_q <= StRd; end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("request taken while a result waits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MaxLen))
    else $error("length beyond store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_rsp_o))
    else $error("result changed while stalled");
endmodule
